[rtl/core/pid_servo_duty_controller_assert.svh]
// Assertion macros for the checker of the PID servo duty controller.
// Depends on nothing; the including scope must provide clk_i and rst_ni.
`ifndef PID_SERVO_DUTY_CONTROLLER_ASSERT_SVH
`define PID_SERVO_DUTY_CONTROLLER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define PSDC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("psdc check failed");

// Checked on every clock edge, reset included.
`define PSDC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("psdc check failed");

`endif

[rtl/core/psdc_pkg.sv]
// Package of the PID servo duty controller: types, register map and constants.
// Depends on nothing; the top level, register file, multiply-accumulate unit and sequencer refer to it by scoped names.
`timescale 1ns / 1ps

package psdc_pkg;

  localparam int unsigned GAIN_FRAC_DEFAULT = 16;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SETPOINT       = 3'd0,
    REG_MAX_COORDINATE = 3'd1,
    REG_GAIN_P         = 3'd2,
    REG_GAIN_D         = 3'd3,
    REG_GAIN_I         = 3'd4,
    REG_PERIOD_TICKS   = 3'd5
  } reg_idx_e;

  localparam logic [15:0]        SETPOINT_RST       = 16'd240;
  localparam logic [15:0]        MAX_COORDINATE_RST = 16'd480;
  localparam logic signed [31:0] GAIN_P_RST         = 32'sd6554;
  localparam logic signed [31:0] GAIN_D_RST         = 32'sd0;
  localparam logic signed [31:0] GAIN_I_RST         = 32'sd0;
  localparam logic [15:0]        PERIOD_TICKS_RST   = 16'd25000;

  typedef struct packed {
    logic [15:0]        setpoint;
    logic [15:0]        max_coordinate;
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_d;
    logic signed [31:0] gain_i;
    logic [15:0]        period_ticks;
  } cfg_t;

  // Shared multiply-accumulate unit.
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W   = 64;

  // Weight of the second partial product of the reciprocal and of the error sum.
  localparam int unsigned RECIP_SPLIT = 14;
  localparam int unsigned WORD_SPLIT  = 16;

  typedef enum logic [1:0] {
    SHIFT_NONE  = 2'd0,
    SHIFT_RECIP = 2'd1,
    SHIFT_WORD  = 2'd2
  } shift_e;

  typedef struct packed {
    logic                      valid;
    logic                      clear;
    shift_e                    shift;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mac_op_t;

  // Duty bands.
  localparam logic [9:0] DUTY_POS_BASE = 10'd722;
  localparam logic [9:0] DUTY_POS_MAX  = 10'd1000;
  localparam logic [9:0] DUTY_POS_LOW  = 10'd720;
  localparam logic [9:0] DUTY_NEG_BASE = 10'd671;
  localparam logic [9:0] DUTY_NEG_HIGH = 10'd672;
  localparam logic [9:0] DUTY_NEG_MIN  = 10'd393;
  localparam int         BAND_SPAN     = 278;
  localparam int         POS_LOW_EDGE  = 5;

  // Division by 10000 as a multiply by ceil(2^40 / 10000); exact for the
  // 26 bit products of period and duty.
  localparam int unsigned     RECIP_W     = 27;
  localparam logic [26:0]     DUTY_RECIP  = 27'd109951163;
  localparam int unsigned     RECIP_SHIFT = 40;
  localparam int unsigned     X_W         = 26;
  localparam int unsigned     QUOT_W      = 13;

  localparam int unsigned     COMPARE_SHIFT  = 7;
  localparam logic [19:0]     COMPARE_OFFSET = 20'd128;

  typedef struct packed {
    logic        valid;
    logic        direction;
    logic [9:0]  duty;
    logic [19:0] compare_word;
  } result_t;

endpackage

[rtl/core/pid_servo_duty_controller.sv]
// Top level of the PID servo duty controller: configuration registers,
// sequencer, shared multiply-accumulate unit and output register. Uses psdc_pkg.
//
// Each request on the input channel carries one measured coordinate for one
// control tick. The coordinate is clamped to max_coordinate, the error against
// setpoint is formed, and the previous error and a saturating 32 bit error sum
// are updated. The PID value gain_p*e + gain_d*(e - previous) + gain_i*sum is
// built exactly in a 64 bit accumulator with GAIN_FRACTION_BITS fraction bits,
// mapped to a duty in the forward band (720 to 1000) or the reverse band (393
// to 672), and scaled by period_ticks into the timer compare word. The input
// stalls from acceptance until the result is loaded into the output register
// and is free again after that, so the block takes no new request before the
// output register has taken the last result. The steps are set by the single
// shared 32 x 18 bit multiplier: the error is formed, four products and a
// drain build the PID sum, the sum is mapped to a duty, one product and a
// drain give period times duty, two products and a drain divide that by 10000
// by reciprocal, the compare word is formed and the result is handed over.
// A finished result waits in the output register, and the next request is
// taken while it is still stalled there.
// Configuration writes are accepted in every cycle and must only be made
// while no request is in flight.
`timescale 1ns / 1ps

module pid_servo_duty_controller #(
  parameter int unsigned GAIN_FRACTION_BITS = psdc_pkg::GAIN_FRAC_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [psdc_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [psdc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Input channel.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [15:0]                      coordinate_i,
  // Result channel.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             direction_o,
  output logic [9:0]                       duty_o,
  output logic [19:0]                      compare_word_o
);

  psdc_pkg::cfg_t                     cfg;
  psdc_pkg::mac_op_t                  mac_op;
  logic signed [psdc_pkg::ACC_W-1:0]  mac_acc;
  psdc_pkg::result_t                  res;
  logic                               res_ready;

  logic        out_valid_q;
  logic        direction_q;
  logic [9:0]  duty_q;
  logic [19:0] compare_word_q;

  psdc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  psdc_seq #(
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .coordinate_i (coordinate_i),
    .acc_i        (mac_acc),
    .op_o         (mac_op),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  psdc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .acc_o  (mac_acc)
  );

  // The output register takes a new result when it is empty or when its
  // current result leaves in the same cycle.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      direction_q    <= res.direction;
      duty_q         <= res.duty;
      compare_word_q <= res.compare_word;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign direction_o    = direction_q;
  assign duty_o         = duty_q;
  assign compare_word_o = compare_word_q;

endmodule

[rtl/core/psdc_cfg.sv]
// Configuration register file of the PID servo duty controller.
// Depends on psdc_pkg for the register map, reset values and cfg_t.
`timescale 1ns / 1ps

module psdc_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [psdc_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [psdc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output psdc_pkg::cfg_t                      cfg_o
);

  psdc_pkg::cfg_t cfg_q;

  // Writes are always taken, so the port never holds off.
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint       <= psdc_pkg::SETPOINT_RST;
      cfg_q.max_coordinate <= psdc_pkg::MAX_COORDINATE_RST;
      cfg_q.gain_p         <= psdc_pkg::GAIN_P_RST;
      cfg_q.gain_d         <= psdc_pkg::GAIN_D_RST;
      cfg_q.gain_i         <= psdc_pkg::GAIN_I_RST;
      cfg_q.period_ticks   <= psdc_pkg::PERIOD_TICKS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (psdc_pkg::reg_idx_e'(cfg_index_i))
        psdc_pkg::REG_SETPOINT:       cfg_q.setpoint       <= cfg_data_i[15:0];
        psdc_pkg::REG_MAX_COORDINATE: cfg_q.max_coordinate <= cfg_data_i[15:0];
        psdc_pkg::REG_GAIN_P:         cfg_q.gain_p         <= $signed(cfg_data_i);
        psdc_pkg::REG_GAIN_D:         cfg_q.gain_d         <= $signed(cfg_data_i);
        psdc_pkg::REG_GAIN_I:         cfg_q.gain_i         <= $signed(cfg_data_i);
        psdc_pkg::REG_PERIOD_TICKS:   cfg_q.period_ticks   <= cfg_data_i[15:0];
        default: begin
          // Indexes beyond the register map are ignored.
        end
      endcase
    end
  end

endmodule

[rtl/core/psdc_mac.sv]
// Shared signed multiply-accumulate unit: registered 32 x 18 product, then a
// 64 bit accumulate with an optional left shift. Depends on psdc_pkg.
`timescale 1ns / 1ps

module psdc_mac (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  psdc_pkg::mac_op_t                       op_i,
  output logic signed [psdc_pkg::ACC_W-1:0]       acc_o
);

  logic signed [psdc_pkg::PROD_W-1:0] prod_q;
  logic                               pend_q;
  logic                               clear_q;
  psdc_pkg::shift_e                   shift_q;
  logic signed [psdc_pkg::ACC_W-1:0]  acc_q;
  logic signed [psdc_pkg::ACC_W-1:0]  prod_ext;
  logic signed [psdc_pkg::ACC_W-1:0]  addend;
  logic signed [psdc_pkg::ACC_W-1:0]  acc_d;

  always_comb begin
    prod_ext = {{(psdc_pkg::ACC_W - psdc_pkg::PROD_W){prod_q[psdc_pkg::PROD_W-1]}}, prod_q};
    unique case (shift_q)
      psdc_pkg::SHIFT_NONE:  addend = prod_ext;
      psdc_pkg::SHIFT_RECIP: addend = prod_ext <<< psdc_pkg::RECIP_SPLIT;
      psdc_pkg::SHIFT_WORD:  addend = prod_ext <<< psdc_pkg::WORD_SPLIT;
      default:               addend = prod_ext;
    endcase
    acc_d = (clear_q ? '0 : acc_q) + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= op_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.valid) begin
      prod_q  <= op_i.a * op_i.b;
      clear_q <= op_i.clear;
      shift_q <= op_i.shift;
    end
    if (pend_q) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

[rtl/core/psdc_seq.sv]
// Sequencer of the PID servo duty controller: error, error state, issue of
// the products to the shared unit, duty mapping and compare word. Uses psdc_pkg.
`timescale 1ns / 1ps

module psdc_seq #(
  parameter int unsigned GAIN_FRACTION_BITS = psdc_pkg::GAIN_FRAC_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  psdc_pkg::cfg_t                     cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [15:0]                        coordinate_i,
  input  logic signed [psdc_pkg::ACC_W-1:0]  acc_i,
  output psdc_pkg::mac_op_t                  op_o,
  input  logic                               res_ready_i,
  output psdc_pkg::result_t                  res_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_IL,
    ST_MUL_IH,
    ST_DRAIN_PID,
    ST_MAP,
    ST_MUL_X,
    ST_DRAIN_X,
    ST_MUL_RL,
    ST_MUL_RH,
    ST_DRAIN_Q,
    ST_QUOT,
    ST_DONE
  } state_e;

  localparam logic signed [63:0] ONE      = 64'sd1 <<< GAIN_FRACTION_BITS;
  localparam logic signed [63:0] POS_TOP  = 64'(psdc_pkg::BAND_SPAN) <<< GAIN_FRACTION_BITS;
  localparam logic signed [63:0] POS_LOW  = 64'(psdc_pkg::POS_LOW_EDGE) <<< GAIN_FRACTION_BITS;
  localparam logic signed [63:0] NEG_HIGH = -ONE;
  localparam logic signed [63:0] NEG_LOW  = -POS_TOP;

  state_e                              state_q;
  logic [15:0]                         coord_q;
  logic signed [16:0]                  err_q;
  logic signed [17:0]                  diff_q;
  logic signed [16:0]                  prev_err_q;
  logic signed [31:0]                  sum_q;
  logic [psdc_pkg::X_W-1:0]            x_q;
  logic                                dir_q;
  logic [9:0]                          duty_q;
  logic [19:0]                         cmp_q;

  logic signed [16:0]                  err_c;
  logic signed [32:0]                  sum_ext;
  logic signed [31:0]                  sum_sat;
  logic signed [63:0]                  pid_shift;
  logic                                dir_c;
  logic [9:0]                          duty_c;
  logic [psdc_pkg::QUOT_W-1:0]         quot_c;
  logic [19:0]                         cmp_c;

  // Error and saturating error sum.
  always_comb begin
    err_c   = $signed({1'b0, cfg_i.setpoint}) - $signed({1'b0, coord_q});
    sum_ext = {sum_q[31], sum_q} + {{16{err_c[16]}}, err_c};
    if (sum_ext[32] != sum_ext[31]) begin
      sum_sat = sum_ext[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sum_sat = sum_ext[31:0];
    end
  end

  // Duty band mapping of the finished PID sum.
  always_comb begin
    pid_shift = acc_i >>> GAIN_FRACTION_BITS;
    dir_c     = (acc_i > 64'sd0);
    if (dir_c) begin
      priority if (acc_i > POS_TOP) begin
        duty_c = psdc_pkg::DUTY_POS_MAX;
      end else if (acc_i < POS_LOW) begin
        duty_c = psdc_pkg::DUTY_POS_LOW;
      end else begin
        duty_c = psdc_pkg::DUTY_POS_BASE + pid_shift[9:0];
      end
    end else begin
      priority if (acc_i > NEG_HIGH) begin
        duty_c = psdc_pkg::DUTY_NEG_HIGH;
      end else if (acc_i < NEG_LOW) begin
        duty_c = psdc_pkg::DUTY_NEG_MIN;
      end else begin
        duty_c = psdc_pkg::DUTY_NEG_BASE + pid_shift[9:0];
      end
    end
  end

  always_comb begin
    quot_c = acc_i[psdc_pkg::RECIP_SHIFT +: psdc_pkg::QUOT_W];
    cmp_c  = ({7'd0, quot_c} << psdc_pkg::COMPARE_SHIFT) + psdc_pkg::COMPARE_OFFSET;
  end

  // Operations handed to the shared unit.
  always_comb begin
    op_o = '0;
    unique case (state_q)
      ST_MUL_P: begin
        op_o.valid = 1'b1;
        op_o.clear = 1'b1;
        op_o.a     = cfg_i.gain_p;
        op_o.b     = {err_q[16], err_q};
      end
      ST_MUL_D: begin
        op_o.valid = 1'b1;
        op_o.a     = cfg_i.gain_d;
        op_o.b     = diff_q;
      end
      ST_MUL_IL: begin
        op_o.valid = 1'b1;
        op_o.a     = cfg_i.gain_i;
        op_o.b     = {2'b00, sum_q[15:0]};
      end
      ST_MUL_IH: begin
        op_o.valid = 1'b1;
        op_o.shift = psdc_pkg::SHIFT_WORD;
        op_o.a     = cfg_i.gain_i;
        op_o.b     = {{2{sum_q[31]}}, sum_q[31:16]};
      end
      ST_MUL_X: begin
        op_o.valid = 1'b1;
        op_o.clear = 1'b1;
        op_o.a     = {16'd0, cfg_i.period_ticks};
        op_o.b     = {8'd0, duty_q};
      end
      ST_MUL_RL: begin
        op_o.valid = 1'b1;
        op_o.clear = 1'b1;
        op_o.a     = {6'd0, acc_i[psdc_pkg::X_W-1:0]};
        op_o.b     = {4'd0, psdc_pkg::DUTY_RECIP[psdc_pkg::RECIP_SPLIT-1:0]};
      end
      ST_MUL_RH: begin
        op_o.valid = 1'b1;
        op_o.shift = psdc_pkg::SHIFT_RECIP;
        op_o.a     = {6'd0, x_q};
        op_o.b     = {5'd0, psdc_pkg::DUTY_RECIP[psdc_pkg::RECIP_W-1:psdc_pkg::RECIP_SPLIT]};
      end
      default: begin
        op_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      prev_err_q <= '0;
      sum_q      <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            coord_q <= (coordinate_i > cfg_i.max_coordinate) ? cfg_i.max_coordinate
                                                              : coordinate_i;
            state_q <= ST_ERR;
          end
        end
        ST_ERR: begin
          err_q      <= err_c;
          diff_q     <= {err_c[16], err_c} - {prev_err_q[16], prev_err_q};
          prev_err_q <= err_c;
          sum_q      <= sum_sat;
          state_q    <= ST_MUL_P;
        end
        ST_MUL_P:     state_q <= ST_MUL_D;
        ST_MUL_D:     state_q <= ST_MUL_IL;
        ST_MUL_IL:    state_q <= ST_MUL_IH;
        ST_MUL_IH:    state_q <= ST_DRAIN_PID;
        ST_DRAIN_PID: state_q <= ST_MAP;
        ST_MAP: begin
          dir_q   <= dir_c;
          duty_q  <= duty_c;
          state_q <= ST_MUL_X;
        end
        ST_MUL_X:     state_q <= ST_DRAIN_X;
        ST_DRAIN_X:   state_q <= ST_MUL_RL;
        ST_MUL_RL: begin
          x_q     <= acc_i[psdc_pkg::X_W-1:0];
          state_q <= ST_MUL_RH;
        end
        ST_MUL_RH:    state_q <= ST_DRAIN_Q;
        ST_DRAIN_Q:   state_q <= ST_QUOT;
        ST_QUOT: begin
          cmp_q   <= cmp_c;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o         = (state_q != ST_IDLE);
  assign res_o.valid        = (state_q == ST_DONE);
  assign res_o.direction    = dir_q;
  assign res_o.duty         = duty_q;
  assign res_o.compare_word = cmp_q;

endmodule

[rtl/core/psdc_checker.sv]
// Port-level checker of the PID servo duty controller and its bind.
// Depends on pid_servo_duty_controller_assert.svh and the top level's ports.
`timescale 1ns / 1ps

`include "pid_servo_duty_controller_assert.svh"

module psdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        direction_o,
  input logic [9:0]  duty_o,
  input logic [19:0] compare_word_o
);

  // A delivered duty lies in the band that its direction selects.
  `PSDC_ASSERT(a_forward_band, out_valid_o && direction_o |-> duty_o >= 10'd720 && duty_o <= 10'd1000)
  `PSDC_ASSERT(a_reverse_band, out_valid_o && !direction_o |-> duty_o >= 10'd393 && duty_o <= 10'd672)

  // The compare word is a whole multiple of the timer step and never zero.
  `PSDC_ASSERT(a_compare_step, out_valid_o |-> compare_word_o[6:0] == 7'd0 && compare_word_o != 20'd0)

  // A request keeps the block busy on the next cycle.
  `PSDC_ASSERT(a_busy_after_request, in_valid_i && !in_stall_o |=> in_stall_o)

  // A stalled result stays and holds its value.
  `PSDC_ASSERT(a_result_held, out_valid_o && out_stall_i |=> out_valid_o && $stable(duty_o) && $stable(compare_word_o))

endmodule

bind pid_servo_duty_controller psdc_checker u_psdc_checker (.*);
